/* hdl/cluster_mean_direction_estimator_defines.svh */
// Assertion macros shared by the estimator RTL.
`ifndef CLUSTER_MEAN_DIRECTION_ESTIMATOR_DEFINES_SVH
`define CLUSTER_MEAN_DIRECTION_ESTIMATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define CMDE_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define CMDE_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/cmde_pkg.sv */
// Types and constants of the cluster mean direction estimator.
`timescale 1ns / 1ps
package cmde_pkg;

  localparam int SUM_W      = 40;
  localparam int HALF_W     = 20;
  localparam int CNT_W      = 20;
  localparam int LEN_W      = 7;
  localparam int SQ_W       = 86;
  localparam int NORM_W     = 43;
  localparam int DIV_NUM_W  = 54;
  localparam int DIR_SHIFT  = 14;
  localparam int CFG_DATA_W = 7;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_ACCUM  = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  localparam logic CFG_NUM_CLUSTERS  = 1'b0;
  localparam logic CFG_SERIES_LENGTH = 1'b1;

  localparam logic [4:0] NUM_CLUSTERS_RST  = 5'd16;
  localparam logic [6:0] SERIES_LENGTH_RST = 7'd64;

  localparam logic [14:0] DIR_ONE = 15'd16384;

  typedef struct packed {
    logic [1:0]         op;
    logic [3:0]         cluster;
    logic [5:0]         time_index;
    logic signed [15:0] sample;
    logic               in_mask;
  } in_t;

  typedef struct packed {
    logic [3:0]         cluster_res;
    logic [5:0]         time_index_res;
    logic signed [15:0] direction;
    logic [15:0]        mean_norm;
    logic [19:0]        voxel_count;
    logic               last;
  } out_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic acc_rd;
    logic acc_wr;
    logic fin_start;
    logic sum_rd;
    logic sq_abs;
    logic mul_ll;
    logic mul_lh;
    logic mul_hh;
    logic idx_inc;
    logic idx_clr;
    logic sqrt_start;
    logic mdiv_start;
    logic mnorm_take;
    logic dir_go;
    logic dir_take;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       acc_ok;
    logic       fin_ok;
    logic       clr_last;
    logic       idx_last;
    logic       sqrt_done;
    logic       div_done;
    logic       cnt_zero;
    logic       dir_zero;
    logic       out_free;
  } status_t;

endpackage

/* hdl/cmde_sqrt.sv */
// Bit-serial integer square root, one root bit per cycle.
`timescale 1ns / 1ps
module cmde_sqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [cmde_pkg::SQ_W-1:0]      rad,
  output logic                           busy,
  output logic                           done,
  output logic [cmde_pkg::NORM_W-1:0]    root
);
  localparam int REM_W = cmde_pkg::NORM_W + 2;
  localparam int STEPS = cmde_pkg::SQ_W / 2;

  logic [cmde_pkg::SQ_W-1:0] rad_sh;
  logic [REM_W-1:0]          rem;
  logic [5:0]                step;
  logic [REM_W+1:0]          rem_sh;
  logic [REM_W+1:0]          trial;
  logic [REM_W+2:0]          diff;
  logic                      ge;

  always_comb begin
    rem_sh = {rem, rad_sh[cmde_pkg::SQ_W-1 -: 2]};
    trial  = {2'b00, root, 2'b01};
    diff   = {1'b0, rem_sh} - {1'b0, trial};
    ge     = !diff[REM_W+2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        rad_sh <= rad;
        rem    <= '0;
        root   <= '0;
        step   <= '0;
      end else if (busy) begin
        rad_sh <= rad_sh << 2;
        rem    <= ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
        root   <= {root[cmde_pkg::NORM_W-2:0], ge};
        step   <= step + 6'd1;
        if (step == 6'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

/* hdl/cmde_div.sv */
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module cmde_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [cmde_pkg::DIV_NUM_W-1:0]  num,
  input  logic [cmde_pkg::NORM_W-1:0]     den,
  output logic                            done,
  output logic [cmde_pkg::DIV_NUM_W-1:0]  quo
);
  localparam int DW = cmde_pkg::NORM_W;
  localparam int NW = cmde_pkg::DIV_NUM_W;

  logic [DW-1:0] den_r;
  logic [DW-1:0] rem;
  logic [5:0]    step;
  logic          busy;
  logic [DW:0]   rem_sh;
  logic [DW+1:0] diff;
  logic          ge;

  always_comb begin
    rem_sh = {rem, quo[NW-1]};
    diff   = {1'b0, rem_sh} - {2'b00, den_r};
    ge     = !diff[DW+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        quo   <= num;
        den_r <= den;
        rem   <= '0;
        step  <= '0;
      end else if (busy) begin
        rem  <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
        quo  <= {quo[NW-2:0], ge};
        step <= step + 6'd1;
        if (step == 6'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

/* hdl/cmde_datapath.sv */
// Datapath: sum and count memories, squaring, norm, division, result register.
`timescale 1ns / 1ps
`include "cluster_mean_direction_estimator_defines.svh"
module cmde_datapath #(
  parameter int MAX_CLUSTERS = 16,
  parameter int MAX_SERIES   = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  cmde_pkg::in_t                    in_data,
  input  cmde_pkg::cmd_t                   cmd,
  output cmde_pkg::status_t                status,
  input  logic                             cfg_valid,
  input  logic                             cfg_index,
  input  logic [cmde_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output cmde_pkg::out_t                   out_data
);
  localparam int DEPTH  = MAX_CLUSTERS * MAX_SERIES;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CL_W   = $clog2(MAX_CLUSTERS);
  localparam int SW     = cmde_pkg::SUM_W;
  localparam int HW     = cmde_pkg::HALF_W;

  // config
  logic [4:0]                 num_clusters;
  logic [6:0]                 series_length;
  logic [cmde_pkg::LEN_W-1:0] len_eff;

  // captured beat
  logic [1:0]         op_r;
  logic [3:0]         cl_r;
  logic [5:0]         t_r;
  logic signed [15:0] smp_r;
  logic               mask_r;

  // memories
  logic signed [SW-1:0]         sum_mem [DEPTH];
  logic [cmde_pkg::CNT_W-1:0]   cnt_mem [MAX_CLUSTERS];
  logic signed [SW-1:0]         sum_rd;
  logic [cmde_pkg::CNT_W-1:0]   cnt_rd;
  logic [ADDR_W-1:0]            clr_ctr;
  logic                         clr_last;

  logic [cmde_pkg::LEN_W-1:0]   idx;
  logic [CL_W-1:0]              cl_idx;
  logic [ADDR_W-1:0]            rd_addr;
  logic [ADDR_W-1:0]            acc_addr;
  logic signed [SW:0]           acc_sum;
  logic signed [SW-1:0]         acc_sat;
  logic [SW:0]                  abs_wide;
  logic [SW-1:0]                abs_rd;

  // squaring
  logic [SW-1:0]              a_r;
  logic [HW-1:0]              mul_a;
  logic [HW-1:0]              mul_b;
  logic [2*HW-1:0]            mul_p;
  logic [cmde_pkg::SQ_W-1:0]  prod_next;
  logic [cmde_pkg::SQ_W-1:0]  prod_r;
  logic                       prod_v;
  logic [cmde_pkg::SQ_W-1:0]  sq_acc;

  // norm and division
  logic                              sqrt_start;
  logic                              sqrt_busy;
  logic                              sqrt_done;
  logic [cmde_pkg::NORM_W-1:0]       sqrt_root;
  logic [cmde_pkg::NORM_W-1:0]       norm_r;
  logic                              div_start;
  logic                              div_done;
  logic [cmde_pkg::DIV_NUM_W-1:0]    div_num;
  logic [cmde_pkg::NORM_W-1:0]       div_den;
  logic [cmde_pkg::DIV_NUM_W-1:0]    div_quo;
  logic [15:0]                       mnorm_r;
  logic [14:0]                       dir_q;
  logic                              dir_neg;
  logic                              dir_zero;
  logic signed [15:0]                dir_val;

  // config registers, stored as written; the usable range is applied where they are read
  always_ff @(posedge clk) begin
    if (rst) begin
      num_clusters  <= cmde_pkg::NUM_CLUSTERS_RST;
      series_length <= cmde_pkg::SERIES_LENGTH_RST;
    end else if (cfg_valid) begin
      if (cfg_index == cmde_pkg::CFG_NUM_CLUSTERS) begin
        num_clusters <= cfg_data[4:0];
      end else begin
        series_length <= cfg_data;
      end
    end
  end

  always_comb begin
    if (series_length == '0) begin
      len_eff = cmde_pkg::LEN_W'(1);
    end else if (32'(series_length) > MAX_SERIES) begin
      len_eff = cmde_pkg::LEN_W'(MAX_SERIES);
    end else begin
      len_eff = series_length;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_data.op;
      cl_r   <= in_data.cluster;
      t_r    <= in_data.time_index;
      smp_r  <= in_data.sample;
      mask_r <= in_data.in_mask;
    end
  end

  always_comb begin
    cl_idx   = CL_W'(cl_r);
    acc_addr = ADDR_W'(cl_idx) * ADDR_W'(MAX_SERIES) + ADDR_W'(t_r);
    rd_addr  = cmd.acc_rd ? acc_addr
                          : ADDR_W'(cl_idx) * ADDR_W'(MAX_SERIES) + ADDR_W'(idx);
    clr_last = (clr_ctr == ADDR_W'(DEPTH - 1));
    acc_sum  = {sum_rd[SW-1], sum_rd} + (SW+1)'(smp_r);
    if (acc_sum[SW] != acc_sum[SW-1]) begin
      acc_sat = acc_sum[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      acc_sat = acc_sum[SW-1:0];
    end
    abs_wide = sum_rd[SW-1] ? -{sum_rd[SW-1], sum_rd} : {1'b0, sum_rd};
    abs_rd   = abs_wide[SW-1:0];
  end

  // sum memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      sum_mem[clr_ctr] <= '0;
    end else if (cmd.acc_wr) begin
      sum_mem[acc_addr] <= acc_sat;
    end
    if (cmd.acc_rd || cmd.sum_rd) begin
      sum_rd <= sum_mem[rd_addr];
    end
  end

  // count memory
  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      if (32'(clr_ctr) < MAX_CLUSTERS) begin
        cnt_mem[CL_W'(clr_ctr)] <= '0;
      end
    end else if (cmd.acc_wr) begin
      if ({1'b0, t_r} == len_eff - 1'b1 && cnt_rd != '1) begin
        cnt_mem[cl_idx] <= cnt_rd + 1'b1;
      end
    end
    if (cmd.acc_rd || cmd.fin_start) begin
      cnt_rd <= cnt_mem[cl_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_ctr <= '0;
    end else if (cmd.clr_step) begin
      clr_ctr <= clr_last ? '0 : clr_ctr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_start || cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
  end

  // squares built from three 20x20 partial products
  always_comb begin
    mul_a = a_r[HW-1:0];
    mul_b = a_r[HW-1:0];
    if (cmd.mul_lh) begin
      mul_a = a_r[SW-1:HW];
    end else if (cmd.mul_hh) begin
      mul_a = a_r[SW-1:HW];
      mul_b = a_r[SW-1:HW];
    end
    mul_p = mul_a * mul_b;
    if (cmd.mul_lh) begin
      prod_next = cmde_pkg::SQ_W'(mul_p) << (HW + 1);
    end else if (cmd.mul_hh) begin
      prod_next = cmde_pkg::SQ_W'(mul_p) << (2 * HW);
    end else begin
      prod_next = cmde_pkg::SQ_W'(mul_p);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_abs) begin
      a_r <= abs_rd;
    end
    prod_r <= prod_next;
    if (rst) begin
      prod_v <= 1'b0;
    end else begin
      prod_v <= cmd.mul_ll || cmd.mul_lh || cmd.mul_hh;
    end
    if (cmd.fin_start) begin
      sq_acc <= '0;
    end else if (prod_v) begin
      sq_acc <= sq_acc + prod_r;
    end
  end

  assign sqrt_start = cmd.sqrt_start;

  cmde_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .rad   (sq_acc),
    .busy  (sqrt_busy),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  assign dir_zero  = (cnt_rd == '0) || (norm_r == '0);
  assign div_start = cmd.mdiv_start || (cmd.dir_go && !dir_zero);

  always_comb begin
    if (cmd.mdiv_start) begin
      div_num = cmde_pkg::DIV_NUM_W'(norm_r) + cmde_pkg::DIV_NUM_W'(cnt_rd >> 1);
      div_den = cmde_pkg::NORM_W'(cnt_rd);
    end else begin
      div_num = {abs_rd, {cmde_pkg::DIR_SHIFT{1'b0}}}
              + cmde_pkg::DIV_NUM_W'(norm_r >> 1);
      div_den = norm_r;
    end
  end

  cmde_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (sqrt_done) begin
      norm_r <= sqrt_root;
    end
    if (cmd.fin_start) begin
      mnorm_r <= '0;
    end else if (cmd.mnorm_take && div_done) begin
      mnorm_r <= (|div_quo[cmde_pkg::DIV_NUM_W-1:16]) ? 16'hFFFF : div_quo[15:0];
    end
    if (cmd.dir_go) begin
      dir_neg <= sum_rd[SW-1];
      dir_q   <= '0;
    end else if (cmd.dir_take && div_done) begin
      dir_q <= (div_quo > cmde_pkg::DIV_NUM_W'(cmde_pkg::DIR_ONE))
             ? cmde_pkg::DIR_ONE : div_quo[14:0];
    end
  end

  assign dir_val = dir_neg ? -$signed({1'b0, dir_q}) : $signed({1'b0, dir_q});

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      out_data.cluster_res    <= cl_r;
      out_data.time_index_res <= 6'(idx);
      out_data.direction      <= dir_val;
      out_data.mean_norm      <= mnorm_r;
      out_data.voxel_count    <= cnt_rd;
      out_data.last           <= (idx == len_eff - 1'b1);
    end
  end

  always_comb begin
    status.op        = op_r;
    status.acc_ok    = mask_r && (32'(cl_r) < MAX_CLUSTERS)
                     && ({1'b0, cl_r} < num_clusters || cl_r == '0)
                     && ({1'b0, t_r} < len_eff);
    status.fin_ok    = (32'(cl_r) < MAX_CLUSTERS)
                     && ({1'b0, cl_r} < num_clusters || cl_r == '0);
    status.clr_last  = clr_last;
    status.idx_last  = (idx == len_eff - 1'b1);
    status.sqrt_done = sqrt_done;
    status.div_done  = div_done;
    status.cnt_zero  = (cnt_rd == '0);
    status.dir_zero  = dir_zero;
    status.out_free  = !out_valid || out_ready;
  end

  `CMDE_ASSERT_IMP(a_out_no_overwrite, cmd.out_load, !out_valid || out_ready, "result beat overwritten")
  `CMDE_ASSERT_NXT(a_clr_wrap, cmd.clr_step && clr_last, clr_ctr == '0, "clear sweep did not wrap")
  `CMDE_ASSERT_IMP(a_sqrt_idle, sqrt_start, !sqrt_busy, "square root restarted while busy")

endmodule

/* hdl/cmde_ctrl.sv */
// Controller: sequences clear, accumulate and finish over the datapath.
`timescale 1ns / 1ps
module cmde_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output cmde_pkg::cmd_t       cmd,
  input  cmde_pkg::status_t    status
);
  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DECODE, ST_ACC_RD, ST_ACC_WR, ST_FIN,
    ST_SQ_RD, ST_SQ_ABS, ST_MUL_LL, ST_MUL_LH, ST_MUL_HH, ST_SQ_NEXT,
    ST_SQRT_GO, ST_SQRT_WAIT, ST_MDIV_GO, ST_MDIV_WAIT,
    ST_DIR_RD, ST_DIR_GO, ST_DIR_WAIT, ST_DIR_OUT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (status.op)
          cmde_pkg::OP_CLEAR:  state_next = ST_CLEAR;
          cmde_pkg::OP_ACCUM:  state_next = status.acc_ok ? ST_ACC_RD : ST_IDLE;
          cmde_pkg::OP_FINISH: state_next = status.fin_ok ? ST_FIN : ST_IDLE;
          default:             state_next = ST_IDLE;
        endcase
      end
      ST_ACC_RD: begin
        cmd.acc_rd = 1'b1;
        state_next = ST_ACC_WR;
      end
      ST_ACC_WR: begin
        cmd.acc_wr = 1'b1;
        state_next = ST_IDLE;
      end
      ST_FIN: begin
        cmd.fin_start = 1'b1;
        state_next    = ST_SQ_RD;
      end
      ST_SQ_RD: begin
        cmd.sum_rd = 1'b1;
        state_next = ST_SQ_ABS;
      end
      ST_SQ_ABS: begin
        cmd.sq_abs = 1'b1;
        state_next = ST_MUL_LL;
      end
      ST_MUL_LL: begin
        cmd.mul_ll = 1'b1;
        state_next = ST_MUL_LH;
      end
      ST_MUL_LH: begin
        cmd.mul_lh = 1'b1;
        state_next = ST_MUL_HH;
      end
      ST_MUL_HH: begin
        cmd.mul_hh = 1'b1;
        state_next = ST_SQ_NEXT;
      end
      ST_SQ_NEXT: begin
        cmd.idx_inc = 1'b1;
        state_next  = status.idx_last ? ST_SQRT_GO : ST_SQ_RD;
      end
      ST_SQRT_GO: begin
        cmd.sqrt_start = 1'b1;
        cmd.idx_clr    = 1'b1;
        state_next     = ST_SQRT_WAIT;
      end
      ST_SQRT_WAIT: begin
        if (status.sqrt_done) state_next = status.cnt_zero ? ST_DIR_RD : ST_MDIV_GO;
      end
      ST_MDIV_GO: begin
        cmd.mdiv_start = 1'b1;
        state_next     = ST_MDIV_WAIT;
      end
      ST_MDIV_WAIT: begin
        cmd.mnorm_take = 1'b1;
        if (status.div_done) state_next = ST_DIR_RD;
      end
      ST_DIR_RD: begin
        cmd.sum_rd = 1'b1;
        state_next = ST_DIR_GO;
      end
      ST_DIR_GO: begin
        cmd.dir_go = 1'b1;
        state_next = status.dir_zero ? ST_DIR_OUT : ST_DIR_WAIT;
      end
      ST_DIR_WAIT: begin
        cmd.dir_take = 1'b1;
        if (status.div_done) state_next = ST_DIR_OUT;
      end
      ST_DIR_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          if (status.idx_last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = ST_DIR_RD;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end
endmodule

/* hdl/cluster_mean_direction_estimator.sv */
// Top level of the per-cluster mean direction estimator.
`timescale 1ns / 1ps
// Usage:
//   in_*  : one beat per operation (clear, accumulate sample, finish cluster).
//   out_* : finish gives one beat per time point of the series, last set on
//           the final one; clear, accumulate and ignored beats give none.
//   cfg_* : register writes (0 num_clusters, 1 series_length), always ready;
//           write only while the block is idle.
// Sequences:
//   accumulate: accept, decode, memory read, write back, in turn; no new
//     beat is taken until the write back is done.
//   clear: a sweep over all MAX_CLUSTERS*MAX_SERIES rows, one memory row per cycle.
//   finish: squares of the sums, a 43-step root, a mean norm divide unless
//     the count is zero, then per point a 54-step divide unless count or norm is zero.
// Reset: config returns to 16 clusters / 64 points, then a sweep over all
//   MAX_CLUSTERS*MAX_SERIES rows zeroes sums and counts; in_ready stays low.
// Stalls: results sit in an output register; a stalled receiver holds the
//   finish loop, but the block takes the next input beat once the last
//   result is loaded.
module cluster_mean_direction_estimator #(
  parameter int MAX_CLUSTERS = 16,
  parameter int MAX_SERIES   = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  cmde_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output cmde_pkg::out_t                   out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_index,
  input  logic [cmde_pkg::CFG_DATA_W-1:0]  cfg_data
);
  cmde_pkg::cmd_t    cmd;
  cmde_pkg::status_t status;

  // config writes never stall
  assign cfg_ready = 1'b1;

  cmde_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .status   (status)
  );

  cmde_datapath #(
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .MAX_SERIES   (MAX_SERIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );
endmodule

/* test/tb_cluster_mean_direction_estimator.sv */
// Self-checking testbench for the cluster mean direction estimator.
`timescale 1ns / 1ps
module tb_cluster_mean_direction_estimator;

  localparam int NCL        = 16;
  localparam int NSER       = 64;
  localparam int CYCLE_CAP  = 2000000;
  localparam int SETTLE     = 1200;   // covers a clear sweep plus slack
  localparam int LONG_HOLD  = 1500;
  localparam int HOLD_AT    = 40;
  localparam longint SUM_HI = 64'sd549755813887;
  localparam longint SUM_LO = -64'sd549755813888;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  cmde_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  cmde_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [cmde_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  cluster_mean_direction_estimator u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mirror of the block state.
  longint      acc_sum [NCL*NSER];
  int unsigned vox_cnt [NCL];
  logic [4:0]  reg_clusters;
  logic [6:0]  reg_length;

  cmde_pkg::out_t exp_beats[$];
  int   mismatches = 0;
  int   cycles = 0;
  int   beats_seen = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int used_clusters();
    if (reg_clusters < 1) return 1;
    if (reg_clusters > NCL) return NCL;
    return int'(reg_clusters);
  endfunction

  function automatic int used_length();
    if (reg_length < 1) return 1;
    if (reg_length > NSER) return NSER;
    return int'(reg_length);
  endfunction

  function automatic void clear_sums();
    foreach (acc_sum[i]) acc_sum[i] = 0;
    foreach (vox_cnt[i]) vox_cnt[i] = 0;
  endfunction

  // Finish: root of the summed squares, the mean norm, then per-point unit direction.
  function automatic void finish_cluster(int cl);
    bit [127:0]     sq, cc;
    bit [63:0]      mag, root, cand, q, mn;
    int             len;
    int unsigned    cnt;
    longint         s;
    cmde_pkg::out_t b;
    len  = used_length();
    cnt  = vox_cnt[cl];
    sq   = '0;
    root = '0;
    mn   = '0;
    for (int i = 0; i < len; i++) begin
      s   = acc_sum[cl*NSER + i];
      mag = (s < 0) ? -s : s;
      sq  = sq + {64'b0, mag} * {64'b0, mag};
    end
    for (int k = 63; k >= 0; k--) begin
      cand = root | (64'd1 << k);
      cc   = {64'b0, cand} * {64'b0, cand};
      if (cc <= sq) root = cand;
    end
    if (cnt != 0) begin
      mn = (root + cnt / 2) / cnt;
      if (mn > 65535) mn = 65535;
    end
    for (int i = 0; i < len; i++) begin
      s = acc_sum[cl*NSER + i];
      q = 0;
      if (cnt != 0 && root != 0) begin
        mag = (s < 0) ? -s : s;
        q   = ((mag << cmde_pkg::DIR_SHIFT) + root / 2) / root;
        if (q > cmde_pkg::DIR_ONE) q = 64'(cmde_pkg::DIR_ONE);
      end
      b.cluster_res    = cl[3:0];
      b.time_index_res = i[5:0];
      b.direction      = (s < 0) ? -q[15:0] : q[15:0];
      b.mean_norm      = mn[15:0];
      b.voxel_count    = cnt[19:0];
      b.last           = (i == len - 1);
      exp_beats.push_back(b);
    end
  endfunction

  function automatic void predict_beat(cmde_pkg::in_t x);
    longint s;
    int     len;
    len = used_length();
    case (x.op)
      cmde_pkg::OP_CLEAR: clear_sums();
      cmde_pkg::OP_ACCUM: begin
        if (x.in_mask && x.cluster < used_clusters() && x.time_index < len) begin
          s = acc_sum[x.cluster*NSER + x.time_index] + longint'(x.sample);
          if (s > SUM_HI) s = SUM_HI;
          if (s < SUM_LO) s = SUM_LO;
          acc_sum[x.cluster*NSER + x.time_index] = s;
          if (x.time_index == len - 1 && vox_cnt[x.cluster] < 20'hFFFFF)
            vox_cnt[x.cluster]++;
        end
      end
      cmde_pkg::OP_FINISH: if (x.cluster < used_clusters()) finish_cluster(x.cluster);
      default: ;
    endcase
  endfunction

  // Random wait with occasional quiet stretches of back-to-back beats.
  function automatic int draw_gap(ref int quiet);
    if (quiet == 0 && $urandom_range(0, 9) == 0) quiet = $urandom_range(10, 40);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  int send_quiet = 0;
  int recv_quiet = 0;

  task automatic send_op(cmde_pkg::in_t x, bit predict = 1'b1);
    int gap;
    gap = draw_gap(send_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= x;
    do @(posedge clk); while (!in_ready);
    if (predict) predict_beat(x);
  endtask

  task automatic write_reg(logic idx, logic [cmde_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == cmde_pkg::CFG_NUM_CLUSTERS) reg_clusters = val[4:0];
    else                                   reg_length   = val[6:0];
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (exp_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off so the block backs up.
  initial begin
    cmde_pkg::out_t want;
    int   w;
    @(negedge rst);
    forever begin
      w = draw_gap(recv_quiet);
      if (beats_seen == HOLD_AT) w = LONG_HOLD;
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      beats_seen++;
      if (exp_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %p", out_data);
      end else begin
        want = exp_beats.pop_front();
        if (out_data.cluster_res !== want.cluster_res ||
            out_data.time_index_res !== want.time_index_res ||
            out_data.direction !== want.direction ||
            out_data.mean_norm !== want.mean_norm ||
            out_data.voxel_count !== want.voxel_count ||
            out_data.last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p got %p", want, out_data);
        end
      end
    end
  end

  // Directed rows; rows marked zero_fin are finishes of an empty cluster,
  // whose beats are typed in directly, zero but for cluster, time index and last.
  typedef struct {
    cmde_pkg::in_t op;
    bit            zero_fin;
  } row_t;

  row_t rows[] = '{
    '{'{cmde_pkg::OP_FINISH, 4'd0,  6'd0,  16'sd0,      1'b1}, 1'b1},
    '{'{cmde_pkg::OP_FINISH, 4'd15, 6'd0,  16'sd0,      1'b1}, 1'b1},
    '{'{cmde_pkg::OP_ACCUM,  4'd0,  6'd0,  16'sd32767,  1'b1}, 1'b0},
    '{'{cmde_pkg::OP_ACCUM,  4'd0,  6'd1,  -16'sd32768, 1'b1}, 1'b0},
    '{'{cmde_pkg::OP_ACCUM,  4'd0,  6'd63, 16'sd16384,  1'b1}, 1'b0},
    '{'{cmde_pkg::OP_ACCUM,  4'd0,  6'd5,  16'sd1000,   1'b0}, 1'b0},
    '{'{cmde_pkg::OP_NOP,    4'd15, 6'd63, -16'sd1,     1'b1}, 1'b0},
    '{'{cmde_pkg::OP_FINISH, 4'd0,  6'd0,  16'sd0,      1'b0}, 1'b0},
    '{'{cmde_pkg::OP_ACCUM,  4'd15, 6'd63, -16'sd1,     1'b1}, 1'b0},
    '{'{cmde_pkg::OP_ACCUM,  4'd15, 6'd62, 16'sd1,      1'b1}, 1'b0},
    '{'{cmde_pkg::OP_FINISH, 4'd15, 6'd0,  16'sd0,      1'b0}, 1'b0},
    '{'{cmde_pkg::OP_CLEAR,  4'd0,  6'd0,  16'sd0,      1'b0}, 1'b0},
    '{'{cmde_pkg::OP_FINISH, 4'd0,  6'd0,  16'sd0,      1'b1}, 1'b1}
  };

  // Register settings per random phase, extremes and out-of-range included.
  int ph_clusters[] = '{1, 31, 0, 5, 16, 3};
  int ph_length[]   = '{1, 127, 0, 8, 64, 17};

  initial begin
    cmde_pkg::in_t  x;
    cmde_pkg::out_t b;
    int   tcur, nc, len, r;
    reg_clusters = cmde_pkg::NUM_CLUSTERS_RST;
    reg_length   = cmde_pkg::SERIES_LENGTH_RST;
    clear_sums();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    write_reg(cmde_pkg::CFG_NUM_CLUSTERS, 7'd16);
    write_reg(cmde_pkg::CFG_SERIES_LENGTH, 7'd64);

    foreach (rows[i]) begin
      if (rows[i].zero_fin) begin
        // nothing accumulated: every beat has zero direction, norm and count
        for (int t = 0; t < used_length(); t++) begin
          b = '0;
          b.cluster_res    = rows[i].op.cluster;
          b.time_index_res = t[5:0];
          b.last           = (t == used_length() - 1);
          exp_beats.push_back(b);
        end
        // nothing to predict beyond the typed-in beats
        send_op(rows[i].op, 1'b0);
      end else begin
        send_op(rows[i].op);
      end
    end
    drain();

    foreach (ph_clusters[p]) begin
      write_reg(cmde_pkg::CFG_NUM_CLUSTERS, ph_clusters[p][6:0]);
      write_reg(cmde_pkg::CFG_SERIES_LENGTH, ph_length[p][6:0]);
      nc   = used_clusters();
      len  = used_length();
      tcur = 0;
      x.cluster = 4'($urandom_range(0, nc - 1));
      for (int k = 0; k < 16; k++) begin
        r = $urandom_range(0, 99);
        x.op = cmde_pkg::OP_ACCUM;
        if (r < 4)       x.op = cmde_pkg::OP_CLEAR;
        else if (r < 16) x.op = cmde_pkg::OP_FINISH;
        else if (r < 20) x.op = cmde_pkg::OP_NOP;
        if (x.op == cmde_pkg::OP_ACCUM) begin
          // mostly walk a voxel series in order so counts advance
          if ($urandom_range(0, 9) == 0) x.time_index = 6'($urandom_range(0, 63));
          else begin
            x.time_index = 6'(tcur);
            tcur = (tcur + 1) % len;
            if (tcur == 0) x.cluster = 4'(($urandom_range(0, 7) == 0) ?
                                       $urandom_range(0, 15) : $urandom_range(0, nc - 1));
          end
          case ($urandom_range(0, 7))
            0:       x.sample = 16'sh7FFF;
            1:       x.sample = 16'sh8000;
            default: x.sample = 16'($urandom_range(0, 65535));
          endcase
          x.in_mask = ($urandom_range(0, 9) != 0);
        end else begin
          x.cluster    = 4'($urandom_range(0, 15));
          x.time_index = 6'($urandom_range(0, 63));
          x.sample     = 16'($urandom_range(0, 65535));
          x.in_mask    = 1'($urandom_range(0, 1));
          if (x.op == cmde_pkg::OP_FINISH && x.cluster >= nc && $urandom_range(0, 2) != 0)
            x.cluster = 4'($urandom_range(0, nc - 1));
        end
        send_op(x);
      end
      drain();
    end

    if (mismatches == 0 && exp_beats.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
